FILE: hdl/hcbd_pkg.sv
// Package for the HTTP chunked body decoder.
// Holds the transaction payload types, result and error codes, and the hex digit decoder.
// No dependencies.
`default_nettype none

package hcbd_pkg;

   // Width of a chunk size field, in bits.
   localparam int SIZE_WIDTH = 32;
   localparam int COUNT_WIDTH = 32;
   // Width used to compare a chunk size against the remaining capacity.
   localparam int CMP_WIDTH = (SIZE_WIDTH > COUNT_WIDTH) ? SIZE_WIDTH : COUNT_WIDTH;

   localparam logic [COUNT_WIDTH-1:0] CAPACITY_RESET = COUNT_WIDTH'(65536);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // Input commands.
   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_BODY     = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_ERROR    = 2'd2;

   // Error codes.
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_MALFORMED = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
   localparam logic [1:0] ERR_CAPACITY  = 2'd3;

   // Framing characters.
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_SEMI  = 8'h3b;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]             kind;
      logic [7:0]             body_byte;
      logic [1:0]             error_code;
      logic [COUNT_WIDTH-1:0] consumed_bytes;
      logic [COUNT_WIDTH-1:0] decoded_length;
   } rsp_payload_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   // Decodes one ASCII hex digit of either case.
   function automatic hex_digit_type hex_decode(input logic [7:0] b);
      hex_digit_type result;
      result.valid = 1'b1;
      result.value = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         result.value = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         result.value = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         result.value = 4'(b - 8'h37);
      end else begin
         result.valid = 1'b0;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/http_chunked_body_decoder_top.sv
// Top level of the HTTP chunked body decoder.
// Parses chunk framing one byte per transaction; depends on hcbd_pkg.
`default_nettype none

// The decoder takes one stream byte (or a restart command) per cycle and
// produces at most one result per byte: a decoded body byte, a completion
// report with the stream bytes consumed, or an error. Every byte is handled
// in the cycle it is accepted, by the framing state update that feeds the
// result register, so throughput is one transaction per clock while the
// result register drains. A new byte is accepted whenever the result
// register is empty or is being drained in the same cycle. After a
// completion or an error, bytes are dropped without a result until a restart
// command arrives. The capacity register may be written at any time the
// decoder is idle and applies to the next chunk-size line that ends.
module http_chunked_body_decoder_top
   import hcbd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_payload_type        req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_payload_type             rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [COUNT_WIDTH-1:0] csr_data
);

   typedef enum logic [2:0] {
      PH_SIZE,
      PH_DATA,
      PH_DATA_CR,
      PH_DATA_LF,
      PH_TRAILER,
      PH_DONE,
      PH_ERROR
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [SIZE_WIDTH-1:0]  size_acc_ff, size_acc_in;
   logic [SIZE_WIDTH-1:0]  chunk_rem_ff, chunk_rem_in;
   logic                   digit_seen_ff, digit_seen_in;
   logic                   blank_seen_ff, blank_seen_in;
   logic                   in_ext_ff, in_ext_in;
   logic                   prev_cr_ff, prev_cr_in;
   logic                   line_empty_ff, line_empty_in;
   logic [COUNT_WIDTH-1:0] decoded_ff, decoded_in;
   logic [COUNT_WIDTH-1:0] consumed_ff, consumed_in;
   logic [COUNT_WIDTH-1:0] capacity_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic                   req_accept;
   logic [7:0]             b;
   hex_digit_type          digit;
   logic                   emit;
   logic [COUNT_WIDTH-1:0] room;
   logic                   cap_fail;
   logic                   acc_full;

   // Handshakes: the result register frees up when drained.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign b        = req_data.data_byte;
   assign digit    = hex_decode(b);
   assign room     = capacity_ff - decoded_ff;
   assign cap_fail = (decoded_ff > capacity_ff) ||
                     (CMP_WIDTH'(size_acc_ff) > CMP_WIDTH'(room));
   // Another digit would not fit when the top nibble is already in use.
   assign acc_full = (size_acc_ff[SIZE_WIDTH-1 -: 4] != 4'd0);

   // Framing state update for one accepted transaction.
   always_comb begin
      phase_in      = phase_ff;
      size_acc_in   = size_acc_ff;
      chunk_rem_in  = chunk_rem_ff;
      digit_seen_in = digit_seen_ff;
      blank_seen_in = blank_seen_ff;
      in_ext_in     = in_ext_ff;
      prev_cr_in    = prev_cr_ff;
      line_empty_in = line_empty_ff;
      decoded_in    = decoded_ff;
      consumed_in   = consumed_ff;
      emit          = 1'b0;
      rsp_data_in.kind           = KIND_BODY;
      rsp_data_in.body_byte      = 8'd0;
      rsp_data_in.error_code     = ERR_NONE;
      rsp_data_in.consumed_bytes = '0;
      rsp_data_in.decoded_length = decoded_ff;

      if (req_data.command == CMD_RESTART) begin
         phase_in      = PH_SIZE;
         size_acc_in   = '0;
         chunk_rem_in  = '0;
         digit_seen_in = 1'b0;
         blank_seen_in = 1'b0;
         in_ext_in     = 1'b0;
         prev_cr_in    = 1'b0;
         line_empty_in = 1'b1;
         decoded_in    = '0;
         consumed_in   = '0;
      end else if (phase_ff != PH_DONE && phase_ff != PH_ERROR) begin
         if (consumed_ff != COUNT_MAX) begin
            consumed_in = consumed_ff + 1'b1;
         end

         unique case (phase_ff)
            PH_SIZE: begin
               // A line end is either CRLF after the size or after an extension.
               if ((in_ext_ff || prev_cr_ff) && prev_cr_ff && b == CHAR_LF) begin
                  if (!digit_seen_ff) begin
                     emit = 1'b1;
                     rsp_data_in.error_code = ERR_MALFORMED;
                  end else begin
                     size_acc_in   = '0;
                     digit_seen_in = 1'b0;
                     blank_seen_in = 1'b0;
                     in_ext_in     = 1'b0;
                     prev_cr_in    = 1'b0;
                     line_empty_in = 1'b1;
                     if (size_acc_ff == '0) begin
                        phase_in = PH_TRAILER;
                     end else if (cap_fail) begin
                        emit = 1'b1;
                        rsp_data_in.error_code = ERR_CAPACITY;
                     end else begin
                        chunk_rem_in = size_acc_ff;
                        phase_in     = PH_DATA;
                     end
                  end
               end else if (in_ext_ff) begin
                  prev_cr_in = (b == CHAR_CR);
               end else if (prev_cr_ff) begin
                  // A bare CR in the size field.
                  emit = 1'b1;
                  rsp_data_in.error_code = ERR_MALFORMED;
               end else if (b == CHAR_CR) begin
                  prev_cr_in = 1'b1;
               end else if (b == CHAR_SEMI) begin
                  if (!digit_seen_ff) begin
                     emit = 1'b1;
                     rsp_data_in.error_code = ERR_MALFORMED;
                  end else begin
                     in_ext_in = 1'b1;
                  end
               end else if (b == CHAR_SPACE || b == CHAR_TAB) begin
                  if (digit_seen_ff) begin
                     blank_seen_in = 1'b1;
                  end
               end else if (!digit.valid || blank_seen_ff) begin
                  emit = 1'b1;
                  rsp_data_in.error_code = ERR_MALFORMED;
               end else if (acc_full) begin
                  emit = 1'b1;
                  rsp_data_in.error_code = ERR_OVERFLOW;
               end else begin
                  size_acc_in   = {size_acc_ff[SIZE_WIDTH-5:0], digit.value};
                  digit_seen_in = 1'b1;
               end
            end

            PH_DATA: begin
               decoded_in   = decoded_ff + 1'b1;
               chunk_rem_in = chunk_rem_ff - 1'b1;
               if (chunk_rem_ff == SIZE_WIDTH'(1)) begin
                  phase_in = PH_DATA_CR;
               end
               emit = 1'b1;
               rsp_data_in.kind           = KIND_BODY;
               rsp_data_in.body_byte      = b;
               rsp_data_in.decoded_length = decoded_ff + 1'b1;
            end

            PH_DATA_CR: begin
               if (b != CHAR_CR) begin
                  emit = 1'b1;
                  rsp_data_in.error_code = ERR_MALFORMED;
               end else begin
                  phase_in = PH_DATA_LF;
               end
            end

            PH_DATA_LF: begin
               if (b != CHAR_LF) begin
                  emit = 1'b1;
                  rsp_data_in.error_code = ERR_MALFORMED;
               end else begin
                  size_acc_in   = '0;
                  digit_seen_in = 1'b0;
                  blank_seen_in = 1'b0;
                  in_ext_in     = 1'b0;
                  prev_cr_in    = 1'b0;
                  line_empty_in = 1'b1;
                  phase_in      = PH_SIZE;
               end
            end

            PH_TRAILER: begin
               // Trailer lines run until an empty line.
               if (prev_cr_ff && b == CHAR_LF) begin
                  if (line_empty_ff) begin
                     phase_in = PH_DONE;
                     emit     = 1'b1;
                     rsp_data_in.kind           = KIND_COMPLETE;
                     rsp_data_in.consumed_bytes = consumed_in;
                  end else begin
                     line_empty_in = 1'b1;
                     prev_cr_in    = 1'b0;
                  end
               end else if (b == CHAR_CR) begin
                  prev_cr_in = 1'b1;
                  if (prev_cr_ff) begin
                     line_empty_in = 1'b0;
                  end
               end else begin
                  line_empty_in = 1'b0;
                  prev_cr_in    = 1'b0;
               end
            end

            default: begin
               phase_in = PH_ERROR;
            end
         endcase

         // Any error result moves to the error phase.
         if (emit && rsp_data_in.error_code != ERR_NONE) begin
            phase_in = PH_ERROR;
            rsp_data_in.kind = KIND_ERROR;
         end
      end

      rsp_valid_in = req_accept ? emit : (rsp_valid_ff && !rsp_ready);
   end

   // State, configuration and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIZE;
         size_acc_ff   <= '0;
         chunk_rem_ff  <= '0;
         digit_seen_ff <= 1'b0;
         blank_seen_ff <= 1'b0;
         in_ext_ff     <= 1'b0;
         prev_cr_ff    <= 1'b0;
         line_empty_ff <= 1'b1;
         decoded_ff    <= '0;
         consumed_ff   <= '0;
         capacity_ff   <= CAPACITY_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff      <= phase_in;
            size_acc_ff   <= size_acc_in;
            chunk_rem_ff  <= chunk_rem_in;
            digit_seen_ff <= digit_seen_in;
            blank_seen_ff <= blank_seen_in;
            in_ext_ff     <= in_ext_in;
            prev_cr_ff    <= prev_cr_in;
            line_empty_ff <= line_empty_in;
            decoded_ff    <= decoded_in;
            consumed_ff   <= consumed_in;
         end
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload loads only with a new result.
   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

FILE: sim/chunked_decode_checker.sv
// Result checker for the HTTP chunked body decoder testbench.
// Watches the byte, result and capacity channels, predicts every result and compares it.
// Depends on hcbd_pkg for the payload types and codes.
`timescale 1ns / 1ps

module chunked_decode_checker
   import hcbd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire req_payload_type        req_data,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire rsp_payload_type        rsp_data,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [COUNT_WIDTH-1:0] csr_data,
   output int                          fail_count,
   output int                          outstanding,
   output int                          handled_count,
   output int                          body_count,
   output int                          complete_count,
   output int                          error_count
);

   localparam int MAX_REPORTS = 10;
   // Largest value a chunk size field may hold.
   localparam logic [63:0] SIZE_LIMIT = {64{1'b1}} >> (64 - SIZE_WIDTH);

   typedef enum logic [2:0] {
      SIZE_LINE,
      CHUNK_DATA,
      DATA_CR,
      DATA_LF,
      TRAILER_LINES,
      MSG_DONE,
      MSG_FAILED
   } framing_state_type;

   // Predicted decoder state.
   framing_state_type      state;
   logic [COUNT_WIDTH-1:0] capacity;
   logic [63:0]            size_acc;
   logic [63:0]            chunk_left;
   bit                     digit_seen;
   bit                     blank_after_digit;
   bit                     in_extension;
   bit                     saw_cr;
   bit                     line_blank;
   logic [COUNT_WIDTH-1:0] decoded_total;
   logic [COUNT_WIDTH-1:0] consumed_total;

   rsp_payload_type expected_results[$];
   int failures = 0;
   int handled = 0;
   int bodies = 0;
   int completions = 0;
   int errors = 0;
   int result_count = 0;

   function automatic void clear_line();
      size_acc = '0;
      digit_seen = 1'b0;
      blank_after_digit = 1'b0;
      in_extension = 1'b0;
      saw_cr = 1'b0;
      line_blank = 1'b1;
   endfunction

   function automatic void clear_message();
      clear_line();
      state = SIZE_LINE;
      chunk_left = '0;
      decoded_total = '0;
      consumed_total = '0;
   endfunction

   function automatic rsp_payload_type make_result(input logic [1:0] kind, input logic [7:0] b,
                                                   input logic [1:0] code,
                                                   input logic [COUNT_WIDTH-1:0] consumed);
      rsp_payload_type r;
      r.kind = kind;
      r.body_byte = b;
      r.error_code = code;
      r.consumed_bytes = consumed;
      r.decoded_length = decoded_total;
      return r;
   endfunction

   function automatic bit fail_with(input logic [1:0] code, output rsp_payload_type r);
      state = MSG_FAILED;
      r = make_result(KIND_ERROR, 8'd0, code, '0);
      return 1'b1;
   endfunction

   // A size line has ended with CRLF: start the chunk, go to the trailer, or fail.
   function automatic bit finish_size_line(output rsp_payload_type r);
      logic [63:0] size;
      size = size_acc;
      r = '0;
      if (!digit_seen) return fail_with(ERR_MALFORMED, r);
      clear_line();
      if (size == 0) begin
         state = TRAILER_LINES;
         return 1'b0;
      end
      if (decoded_total > capacity || size > 64'(capacity - decoded_total))
         return fail_with(ERR_CAPACITY, r);
      chunk_left = size;
      state = CHUNK_DATA;
      return 1'b0;
   endfunction

   // Advances the predicted state by one transaction; returns 1 when it yields a result.
   function automatic bit decode_stream_byte(input req_payload_type item,
                                             output rsp_payload_type r);
      logic [7:0] b;
      logic [4:0] digit;
      b = item.data_byte;
      r = '0;
      if (item.command == CMD_RESTART) begin
         clear_message();
         return 1'b0;
      end
      if (state == MSG_DONE || state == MSG_FAILED) return 1'b0;
      if (consumed_total != COUNT_MAX) consumed_total++;

      case (state)
         SIZE_LINE: begin
            // Extension text is skipped up to the CRLF that closes the line.
            if (in_extension) begin
               if (saw_cr && b == CHAR_LF) return finish_size_line(r);
               saw_cr = (b == CHAR_CR);
               return 1'b0;
            end
            if (saw_cr) begin
               if (b == CHAR_LF) return finish_size_line(r);
               return fail_with(ERR_MALFORMED, r);
            end
            if (b == CHAR_CR) begin
               saw_cr = 1'b1;
               return 1'b0;
            end
            if (b == CHAR_SEMI) begin
               if (!digit_seen) return fail_with(ERR_MALFORMED, r);
               in_extension = 1'b1;
               return 1'b0;
            end
            if (b == CHAR_SPACE || b == CHAR_TAB) begin
               if (digit_seen) blank_after_digit = 1'b1;
               return 1'b0;
            end
            // Hex digit of either case; the top bit marks anything else.
            if (b >= 8'h30 && b <= 8'h39) begin
               digit = {1'b0, 4'(b - 8'h30)};
            end else if (b >= 8'h61 && b <= 8'h66) begin
               digit = {1'b0, 4'(b - 8'h61 + 8'd10)};
            end else if (b >= 8'h41 && b <= 8'h46) begin
               digit = {1'b0, 4'(b - 8'h41 + 8'd10)};
            end else begin
               digit = 5'h10;
            end
            if (digit[4] || blank_after_digit) return fail_with(ERR_MALFORMED, r);
            if (size_acc > (SIZE_LIMIT - 64'(digit[3:0])) / 64'd16)
               return fail_with(ERR_OVERFLOW, r);
            size_acc = size_acc * 64'd16 + 64'(digit[3:0]);
            digit_seen = 1'b1;
            return 1'b0;
         end
         CHUNK_DATA: begin
            decoded_total++;
            if (chunk_left > 0) chunk_left--;
            if (chunk_left == 0) state = DATA_CR;
            r = make_result(KIND_BODY, b, ERR_NONE, '0);
            return 1'b1;
         end
         DATA_CR: begin
            if (b != CHAR_CR) return fail_with(ERR_MALFORMED, r);
            state = DATA_LF;
            return 1'b0;
         end
         DATA_LF: begin
            if (b != CHAR_LF) return fail_with(ERR_MALFORMED, r);
            clear_line();
            state = SIZE_LINE;
            return 1'b0;
         end
         TRAILER_LINES: begin
            // An empty line ends the trailer and the message.
            if (saw_cr && b == CHAR_LF) begin
               if (line_blank) begin
                  state = MSG_DONE;
                  r = make_result(KIND_COMPLETE, 8'd0, ERR_NONE, consumed_total);
                  return 1'b1;
               end
               line_blank = 1'b1;
               saw_cr = 1'b0;
               return 1'b0;
            end
            if (saw_cr) line_blank = 1'b0;
            if (b == CHAR_CR) begin
               saw_cr = 1'b1;
            end else begin
               line_blank = 1'b0;
               saw_cr = 1'b0;
            end
            return 1'b0;
         end
         default: begin
            state = MSG_FAILED;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic void compare_field(input string field_name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         failures++;
         if (failures <= MAX_REPORTS)
            $display("[%0t] result %0d, %s: expected %0h, actual %0h",
                     $time, result_count, field_name, want, got);
      end
   endfunction

   // Predict at each accepted byte, then check each accepted result in order.
   always @(posedge clock) begin
      rsp_payload_type predicted;
      if (reset) begin
         capacity = CAPACITY_RESET;
         clear_message();
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) capacity = csr_data;
         if (req_valid && req_ready) begin
            if (req_data.command == CMD_RESTART || !(state == MSG_DONE || state == MSG_FAILED))
               handled++;
            if (decode_stream_byte(req_data, predicted)) begin
               expected_results.push_back(predicted);
               if (predicted.kind == KIND_BODY) bodies++;
               else if (predicted.kind == KIND_COMPLETE) completions++;
               else errors++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("[%0t] result %0d arrived with nothing expected: kind %0h",
                           $time, result_count, rsp_data.kind);
            end else begin
               predicted = expected_results.pop_front();
               compare_field("kind", 32'(predicted.kind), 32'(rsp_data.kind));
               compare_field("body_byte", 32'(predicted.body_byte), 32'(rsp_data.body_byte));
               compare_field("error_code", 32'(predicted.error_code),
                             32'(rsp_data.error_code));
               compare_field("consumed_bytes", predicted.consumed_bytes,
                             rsp_data.consumed_bytes);
               compare_field("decoded_length", predicted.decoded_length,
                             rsp_data.decoded_length);
            end
         end
      end
      fail_count <= failures;
      outstanding <= expected_results.size();
      handled_count <= handled;
      body_count <= bodies;
      complete_count <= completions;
      error_count <= errors;
   end

endmodule

FILE: sim/testbench.sv
// Top of the HTTP chunked body decoder testbench: clock, reset, stimulus and verdict.
// Drives directed and random chunked streams; depends on hcbd_pkg, the decoder top
// and chunked_decode_checker.
`timescale 1ns / 1ps

module testbench;
   import hcbd_pkg::*;

   localparam int ITEM_TARGET = 700;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASES = 6;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_payload_type        req_data;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [COUNT_WIDTH-1:0] csr_data;

   int fail_count;
   int outstanding;
   int handled_count;
   int body_count;
   int complete_count;
   int error_count;

   req_payload_type stream_q[$];
   bit sender_calm = 1'b0;
   int ready_stall = 0;
   int ready_calm = 0;

   http_chunked_body_decoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   chunked_decode_checker result_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .handled_count  (handled_count),
      .body_count     (body_count),
      .complete_count (complete_count),
      .error_count    (error_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gap length: mostly short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(10, 40);
   endfunction

   // Result-side back-pressure: random stalls with calm stretches in between.
   always @(posedge clock) begin
      if (ready_stall > 0) begin
         rsp_ready <= 1'b0;
         ready_stall <= ready_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (ready_calm > 0) ready_calm <= ready_calm - 1;
         else if ($urandom_range(0, 99) < 2) ready_calm <= $urandom_range(50, 300);
         else if ($urandom_range(0, 99) < 30) ready_stall <= pick_gap();
      end
   end

   function automatic void add_byte(input logic [7:0] b);
      req_payload_type item;
      item.command = CMD_BYTE;
      item.data_byte = b;
      stream_q.push_back(item);
   endfunction

   function automatic void add_restart();
      req_payload_type item;
      item.command = CMD_RESTART;
      item.data_byte = 8'($urandom);
      stream_q.push_back(item);
   endfunction

   function automatic void add_crlf();
      add_byte(CHAR_CR);
      add_byte(CHAR_LF);
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   // One hex digit, in random case.
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return 8'h30 + 8'(nib);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
   endfunction

   // Bytes that matter to the framing logic, plus the odd random one.
   function automatic logic [7:0] framing_noise();
      case ($urandom_range(0, 9))
         0: return CHAR_CR;
         1: return CHAR_LF;
         2: return CHAR_SEMI;
         3: return CHAR_SPACE;
         4: return CHAR_TAB;
         5: return 8'h30;
         6: return 8'h66;
         7: return 8'h46;
         8: return 8'h67;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void add_blanks();
      repeat ($urandom_range(1, 2)) add_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
   endfunction

   // Size line with random blanks, leading zeros and an optional extension.
   function automatic void add_size_line(input logic [31:0] size);
      logic [31:0] rest;
      int count;
      if ($urandom_range(0, 4) == 0) add_blanks();
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) add_byte(8'h30);
      count = 1;
      rest = size >> 4;
      while (rest != 0) begin
         count++;
         rest = rest >> 4;
      end
      for (int i = count - 1; i >= 0; i--) add_byte(hex_char(4'(size >> (4 * i))));
      if ($urandom_range(0, 4) == 0) add_blanks();
      if ($urandom_range(0, 4) == 0) begin
         add_byte(CHAR_SEMI);
         repeat ($urandom_range(0, 4))
            add_byte(($urandom_range(0, 7) == 0) ? CHAR_CR : 8'($urandom_range(8'h20, 8'h7e)));
      end
      add_crlf();
   endfunction

   // A well-formed message: a few chunks, the last chunk, trailer lines, the empty line.
   function automatic void add_message(input int max_chunk);
      int size;
      logic [7:0] b;
      repeat ($urandom_range(0, 3)) begin
         size = $urandom_range(1, max_chunk);
         add_size_line(size);
         repeat (size) add_byte(8'($urandom));
         add_crlf();
      end
      add_size_line(32'd0);
      repeat ($urandom_range(0, 2)) begin
         if ($urandom_range(0, 3) == 0) add_byte(CHAR_CR);
         repeat ($urandom_range(1, 6)) begin
            b = 8'($urandom);
            if (b == CHAR_CR || b == CHAR_LF) b = 8'h41;
            add_byte(b);
         end
         add_crlf();
      end
      add_crlf();
   endfunction

   // One transaction on the byte channel, after an optional gap.
   task automatic send_item(input req_payload_type item);
      int gap;
      gap = 0;
      if (!sender_calm && $urandom_range(0, 99) < 25) gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_stream();
      foreach (stream_q[i]) send_item(stream_q[i]);
      stream_q.delete();
   endtask

   // Wait until every predicted result has been taken and the decoder has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [COUNT_WIDTH-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed messages; the rest corrupted, cut short, oversized or noise.
   task automatic random_message();
      int mode;
      int n;
      sender_calm = ($urandom_range(0, 99) < 20);
      if ($urandom_range(0, 99) < 95) add_restart();
      n = stream_q.size();
      mode = $urandom_range(0, 99);
      if (mode < 85) begin
         add_message(($urandom_range(0, 19) == 0) ? 40 : 8);
         if (mode >= 70) begin
            repeat (stream_q.size() - $urandom_range(n + 1, stream_q.size() - 1))
               stream_q.delete(stream_q.size() - 1);
         end else if (mode >= 55) begin
            stream_q[$urandom_range(n, stream_q.size() - 1)].data_byte = framing_noise();
         end
      end else if (mode < 90) begin
         // Size field with more digits than fit.
         add_byte(hex_char(4'($urandom_range(1, 15))));
         repeat ($urandom_range(8, 10)) add_byte(hex_char(4'($urandom)));
         add_crlf();
      end else if (mode < 93) begin
         // Very large chunk that is abandoned after a few bytes.
         add_size_line($urandom | 32'h1000_0000);
         repeat ($urandom_range(0, 4)) add_byte(8'($urandom));
      end else begin
         repeat ($urandom_range(1, 10)) add_byte(framing_noise());
      end
      if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      send_stream();
   endtask

   initial begin
      logic [COUNT_WIDTH-1:0] phase_capacity[PHASES];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty body, then a byte that must be ignored after completion.
      add_text("0");
      add_crlf();
      add_crlf();
      add_text("X");
      // Both extreme body bytes, blanks around the size, an extension and a trailer.
      add_restart();
      add_text(" 2 ;a=b");
      add_crlf();
      add_byte(8'h00);
      add_byte(8'hff);
      add_crlf();
      add_text("0");
      add_crlf();
      add_text("T: v");
      add_crlf();
      add_crlf();
      // Empty size field, ended by ';' and by the line end.
      add_restart();
      add_text(";");
      add_restart();
      add_crlf();
      // Blank between digits, then a bare CR inside the size field.
      add_restart();
      add_text("1 2");
      add_restart();
      add_byte(CHAR_CR);
      add_text("A");
      // Size one digit too long.
      add_restart();
      add_text("FfFfFfFf0");
      // Missing CR, then missing LF, after chunk data.
      add_restart();
      add_text("1");
      add_crlf();
      add_text("ZX");
      add_restart();
      add_text("1");
      add_crlf();
      add_text("Z");
      add_byte(CHAR_CR);
      add_text("X");
      // Decoded total already above a capacity lowered mid-message.
      add_restart();
      add_text("3");
      add_crlf();
      add_text("abc");
      add_crlf();
      send_stream();
      write_capacity(32'd1);
      add_text("1");
      add_crlf();
      send_stream();

      // Random phases, each under its own capacity.
      phase_capacity = '{32'd0, COUNT_MAX, 32'd12, 32'($urandom_range(1, 64)),
                         CAPACITY_RESET, 32'($urandom)};
      for (int p = 0; p < PHASES; p++) begin
         write_capacity(phase_capacity[p]);
         while (handled_count < (p + 1) * ITEM_TARGET / PHASES) random_message();
      end
      wait_idle();

      $display("Covered %0d stream transactions: %0d body bytes, %0d completions, %0d errors.",
               handled_count, body_count, complete_count, error_count);
      $display("Body capacity took %0d values, from zero up to the full 32-bit range.",
               PHASES + 2);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles, %0d results still expected.", CYCLE_LIMIT, outstanding);
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: sim.f
hdl/hcbd_pkg.sv
hdl/http_chunked_body_decoder_top.sv
sim/chunked_decode_checker.sv
sim/testbench.sv
